/* hdl/iffd_pkg.sv */
package iffd_pkg;

   // Parser phases; they double as the role code of the byte taken in that phase.
   localparam logic [1:0] PH_ID      = 2'd0;
   localparam logic [1:0] PH_SIZE    = 2'd1;
   localparam logic [1:0] PH_FTYPE   = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   localparam logic [1:0] ROLE_ID      = PH_ID;
   localparam logic [1:0] ROLE_SIZE    = PH_SIZE;
   localparam logic [1:0] ROLE_FTYPE   = PH_FTYPE;
   localparam logic [1:0] ROLE_PAYLOAD = PH_PAYLOAD;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_SHORT_FORM = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;

   // "FORM" in big-endian ASCII.
   localparam logic [31:0] FORM_TAG_RESET  = 32'h464F_524D;
   localparam logic [31:0] FORM_TYPE_BYTES = 32'd4;

   typedef logic [31:0] csr_data_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic [1:0]  role;
      logic [31:0] chunk_tag;
      logic        payload_first;
      logic        chunk_end;
      logic [1:0]  status;
   } rsp_item_type;

endpackage

/* hdl/iffd_chan_if.sv */
interface iffd_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/iff_chunk_deframer.sv */
// IFF chunk deframer.
// The req_ch channel carries one stream byte per item with a last_byte mark on
// the final byte of the stream. For every item one result leaves on rsp_ch: the
// byte itself, its role (chunk id, size, form type or payload), the chunk tag
// on payload bytes, a first-payload mark, a chunk-end mark and a status code.
// The csr_ch channel writes the form tag, the id that carries a form type; it
// is always ready and should only be written while the block is idle.
// An item accepted on req_ch goes into the input register and its result
// moves on into the result register, which drives rsp_ch, once that is free.
// Throughput is one item per cycle while rsp_ch does not stall; all parsing
// of a byte is a short pass of logic between those two registers, set by
// the 32-bit size add and compare.
// When rsp_ch stalls, the result register holds and the input register still
// takes one more item, after which req_ch.ready drops until the result leaves.
// A synchronous reset empties both registers, returns the parser to waiting
// for a chunk id and restores the form tag to "FORM". A byte marked last also
// returns the parser to that state, so a new stream may follow directly.
module iff_chunk_deframer
   import iffd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   iffd_chan_if.sink   req_ch,
   iffd_chan_if.source rsp_ch,
   iffd_chan_if.sink   csr_ch
);

   // Pipeline registers.
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   logic         advance;

   // Configuration.
   logic [31:0] form_tag_ff;

   // Parser state.
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] left_ff, left_in;
   logic        is_form_ff, is_form_in;
   logic        first_ff, first_in;

   // Helpers for the parse pass.
   logic [31:0] tag_shift;
   logic [31:0] size_shift;
   logic [31:0] padded;
   logic        hdr_done;
   logic        cend;

   // The byte in the input register moves on once the result register is free
   // or is being emptied in this same cycle.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff <= req_ch.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         form_tag_ff <= FORM_TAG_RESET;
      end else if (csr_ch.valid) begin
         form_tag_ff <= csr_ch.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_ID;
         hdr_cnt_ff <= 2'd0;
         tag_ff     <= '0;
         size_ff    <= '0;
         left_ff    <= '0;
         is_form_ff <= 1'b0;
         first_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         tag_ff     <= tag_in;
         size_ff    <= size_in;
         left_ff    <= left_in;
         is_form_ff <= is_form_in;
         first_ff   <= first_in;
      end
   end

   // Header fields are assembled big-endian, one byte per item.
   assign tag_shift  = {tag_ff[23:0], in_item_ff.byte_value};
   assign size_shift = {size_ff[23:0], in_item_ff.byte_value};
   assign hdr_done   = (hdr_cnt_ff == 2'd3);
   // Sizes round up to even; the largest odd size would wrap, so it saturates.
   assign padded     = (size_shift == '1) ? '1 : size_shift + {31'd0, size_shift[0]};

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      tag_in     = tag_ff;
      size_in    = size_ff;
      left_in    = left_ff;
      is_form_in = is_form_ff;
      first_in   = first_ff;
      cend       = 1'b0;

      rsp_item_in.byte_out      = in_item_ff.byte_value;
      rsp_item_in.role          = phase_ff;
      rsp_item_in.chunk_tag     = '0;
      rsp_item_in.payload_first = 1'b0;
      rsp_item_in.status        = STATUS_OK;

      unique case (phase_ff)
         PH_ID: begin
            tag_in     = tag_shift;
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
            if (hdr_done) begin
               is_form_in = (tag_shift == form_tag_ff);
               size_in    = '0;
               phase_in   = PH_SIZE;
            end
         end
         PH_SIZE: begin
            size_in    = size_shift;
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
            if (hdr_done) begin
               left_in = padded;
               if (is_form_ff) begin
                  tag_in   = '0;
                  phase_in = PH_FTYPE;
               end else if (size_shift == '0) begin
                  // An empty chunk ends on its last size byte.
                  cend     = 1'b1;
                  phase_in = PH_ID;
               end else begin
                  first_in = 1'b1;
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_FTYPE: begin
            tag_in     = tag_shift;
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
            if (hdr_done) begin
               if (left_ff < FORM_TYPE_BYTES) begin
                  // A form too small to hold its type is flagged and taken as empty.
                  rsp_item_in.status = STATUS_SHORT_FORM;
                  left_in            = '0;
                  cend               = 1'b1;
                  phase_in           = PH_ID;
               end else begin
                  left_in = left_ff - FORM_TYPE_BYTES;
                  if (left_ff == FORM_TYPE_BYTES) begin
                     cend     = 1'b1;
                     phase_in = PH_ID;
                  end else begin
                     first_in = 1'b1;
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            rsp_item_in.chunk_tag     = tag_ff;
            rsp_item_in.payload_first = first_ff;
            first_in                  = 1'b0;
            if (left_ff != '0) begin
               left_in = left_ff - 32'd1;
            end
            if (left_ff <= 32'd1) begin
               cend     = 1'b1;
               phase_in = PH_ID;
            end
         end
         default: begin
            phase_in = PH_ID;
         end
      endcase

      if (cend) begin
         tag_in = '0;
      end

      // The end of the stream clears the parser whether or not a chunk closed.
      if (in_item_ff.last_byte) begin
         if (!cend) begin
            rsp_item_in.status = STATUS_TRUNCATED;
         end
         phase_in   = PH_ID;
         hdr_cnt_in = 2'd0;
         tag_in     = '0;
         size_in    = '0;
         left_in    = '0;
         is_form_in = 1'b0;
         first_in   = 1'b0;
      end

      rsp_item_in.chunk_end = cend;
   end

`ifndef SYNTHESIS
   a_payload_has_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != '0))
      else $error("payload phase with no bytes left");

   a_first_on_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.payload_first) |-> (rsp_item_ff.role == ROLE_PAYLOAD))
      else $error("first mark on a header byte");

   a_tag_only_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_item_ff.role != ROLE_PAYLOAD)) |-> (rsp_item_ff.chunk_tag == '0))
      else $error("chunk tag on a header byte");

   a_short_form_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_item_ff.status == STATUS_SHORT_FORM))
         |-> (rsp_item_ff.chunk_end && (rsp_item_ff.role == ROLE_FTYPE)))
      else $error("short form flag without chunk end on form type");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.last_byte)
         |=> ((phase_ff == PH_ID) && (hdr_cnt_ff == 2'd0) && (left_ff == '0)))
      else $error("parser not cleared after end of stream");
`endif

endmodule

/* dv/tb_top.sv */
// Testbench for the IFF chunk deframer.
//
// The stimulus process builds IFF byte streams (whole chunks, forms with a
// form type, truncated streams and plain noise) and appends them to a queue.
// A clocked driver offers the queued bytes on req_ch. Every byte that the
// block accepts is run through the chunk parser below, which keeps its own
// copy of the parse state and the form tag. The expected result goes into a
// queue. A clocked monitor takes the results from rsp_ch and compares each one,
// field by field, with the oldest entry in that queue.
module tb_top;
   import iffd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iffd_chan_if #(.payload_type(req_item_type)) req_if ();
   iffd_chan_if #(.payload_type(rsp_item_type)) rsp_if ();
   iffd_chan_if #(.payload_type(csr_data_type)) csr_if ();

   iff_chunk_deframer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Bytes waiting to be offered. The head stays in the queue while it is on
   // the bus and is removed once it has been accepted.
   req_item_type byte_queue[$];
   // Results that the parser model predicts and the block has not sent yet.
   rsp_item_type expected_rsp[$];
   // Stream under construction. The end-of-stream mark is set when the stream
   // is copied into byte_queue.
   logic [7:0]   stream_buf[$];

   // Parser model state and its copy of the form tag.
   logic [1:0]  parse_phase;
   logic [1:0]  hdr_count;
   logic [31:0] tag_shift;
   logic [31:0] size_shift;
   logic [31:0] left_count;
   logic        in_form;
   logic        first_due;
   logic [31:0] form_tag_copy;

   int unsigned bytes_queued  = 0;
   int unsigned results_seen  = 0;
   int unsigned chunk_ends    = 0;
   int unsigned short_forms   = 0;
   int unsigned truncations   = 0;
   int unsigned tag_settings  = 1;
   int unsigned error_count   = 0;

   int unsigned send_gap = 0;
   int unsigned rcv_gap  = 0;
   bit          send_calm = 1'b0;
   bit          rcv_calm  = 1'b0;

   // Back to waiting for a chunk id. This happens at reset and after any byte
   // that is marked as the last byte of a stream.
   function automatic void clear_parse();
      parse_phase = PH_ID;
      hdr_count   = 2'd0;
      tag_shift   = '0;
      size_shift  = '0;
      left_count  = '0;
      in_form     = 1'b0;
      first_due   = 1'b0;
   endfunction

   // Takes one accepted byte, advances the parse state and returns the result
   // that the block has to produce for that byte.
   function automatic rsp_item_type parse_byte(input req_item_type item);
      rsp_item_type r;
      logic [32:0]  padded;
      r = '0;
      r.byte_out = item.byte_value;
      r.role     = parse_phase;
      r.status   = STATUS_OK;
      case (parse_phase)
         PH_ID: begin
            tag_shift = {tag_shift[23:0], item.byte_value};
            hdr_count = hdr_count + 2'd1;
            if (hdr_count == 2'd0) begin
               in_form     = (tag_shift == form_tag_copy);
               size_shift  = '0;
               parse_phase = PH_SIZE;
            end
         end
         PH_SIZE: begin
            size_shift = {size_shift[23:0], item.byte_value};
            hdr_count  = hdr_count + 2'd1;
            if (hdr_count == 2'd0) begin
               // Round odd sizes up to even. The largest odd size would need
               // a 33rd bit, so it is held at all ones.
               padded     = {1'b0, size_shift} + 33'(size_shift[0]);
               left_count = padded[32] ? 32'hFFFF_FFFF : padded[31:0];
               if (in_form) begin
                  tag_shift   = '0;
                  parse_phase = PH_FTYPE;
               end else if (left_count == 0) begin
                  r.chunk_end = 1'b1;
                  parse_phase = PH_ID;
               end else begin
                  first_due   = 1'b1;
                  parse_phase = PH_PAYLOAD;
               end
            end
         end
         PH_FTYPE: begin
            tag_shift = {tag_shift[23:0], item.byte_value};
            hdr_count = hdr_count + 2'd1;
            if (hdr_count == 2'd0) begin
               // A form too short to hold its own type is flagged and
               // treated as empty.
               if (left_count < FORM_TYPE_BYTES) begin
                  r.status   = STATUS_SHORT_FORM;
                  left_count = '0;
               end else begin
                  left_count = left_count - FORM_TYPE_BYTES;
               end
               if (left_count == 0) begin
                  r.chunk_end = 1'b1;
                  parse_phase = PH_ID;
               end else begin
                  first_due   = 1'b1;
                  parse_phase = PH_PAYLOAD;
               end
            end
         end
         default: begin
            r.chunk_tag     = tag_shift;
            r.payload_first = first_due;
            first_due       = 1'b0;
            if (left_count != 0)
               left_count = left_count - 32'd1;
            if (left_count == 0) begin
               r.chunk_end = 1'b1;
               parse_phase = PH_ID;
            end
         end
      endcase
      if (r.chunk_end)
         tag_shift = '0;
      if (item.last_byte) begin
         if (!r.chunk_end)
            r.status = STATUS_TRUNCATED;
         clear_parse();
      end
      return r;
   endfunction

   function automatic int check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Driver. Each byte is followed by a random pause. Now and then it switches
   // into a calm stretch in which bytes go back to back.
   always @(posedge clock) begin
      logic took;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         took = req_if.valid && req_if.ready;
         if (took) begin
            expected_rsp.push_back(parse_byte(req_if.payload));
            void'(byte_queue.pop_front());
            if ($urandom_range(0, 63) == 0)
               send_calm = !send_calm;
            send_gap = send_calm ? 0 : $urandom_range(0, 4);
         end
         // valid is assigned only when the bus is free, so a byte that is
         // offered stays on the bus until it is taken.
         if (!req_if.valid || took) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= byte_queue[0];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. It checks each result and then draws its own random stall. Once
   // every 500 results it holds ready low long enough that the block fills up
   // and has to push back on req_ch.
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rcv_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_rsp.size() == 0) begin
               $error("result with no byte pending: byte_out %h", got.byte_out);
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               error_count += check_field("byte_out", 32'(want.byte_out),
                                          32'(got.byte_out));
               error_count += check_field("role", 32'(want.role), 32'(got.role));
               error_count += check_field("chunk_tag", want.chunk_tag, got.chunk_tag);
               error_count += check_field("payload_first", 32'(want.payload_first),
                                          32'(got.payload_first));
               error_count += check_field("chunk_end", 32'(want.chunk_end),
                                          32'(got.chunk_end));
               error_count += check_field("status", 32'(want.status), 32'(got.status));
               if (want.chunk_end)
                  chunk_ends++;
               if (want.status == STATUS_SHORT_FORM)
                  short_forms++;
               if (want.status == STATUS_TRUNCATED)
                  truncations++;
            end
            results_seen++;
            if ($urandom_range(0, 63) == 0)
               rcv_calm = !rcv_calm;
            rcv_gap = rcv_calm ? 0 : $urandom_range(0, 4);
            if (results_seen % 500 == 250)
               rcv_gap = 80;
         end
         if (rcv_gap > 0) begin
            rcv_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stream building.

   task automatic push_item(input logic [7:0] value, input logic last);
      req_item_type item;
      item.byte_value = value;
      item.last_byte  = last;
      byte_queue.push_back(item);
      bytes_queued++;
   endtask

   task automatic put_word(input logic [31:0] word);
      for (int i = 3; i >= 0; i--)
         stream_buf.push_back(word[8*i +: 8]);
   endtask

   // Appends one chunk to the stream: id, big-endian size, the form type when
   // the id is the form tag, then the payload including any pad byte. The
   // payload is cut to max_body bytes, which makes a chunk with a huge size
   // end in a truncated stream. Some forms start their payload with the form
   // tag, like a nested form, which the block must not descend into.
   task automatic add_chunk(input logic [31:0] id, input logic [31:0] size,
                            input logic [31:0] ftype, input int unsigned max_body);
      logic [32:0]     padded;
      longint unsigned body;
      bit              nest;
      put_word(id);
      put_word(size);
      padded = {1'b0, size} + 33'(size[0]);
      if (padded[32])
         padded = 33'h0_FFFF_FFFF;
      body = 64'(padded);
      if (id == form_tag_copy) begin
         put_word(ftype);
         body = (padded < 33'd4) ? 64'd0 : 64'(padded - 33'd4);
      end
      if (body > 64'(max_body))
         body = 64'(max_body);
      nest = (id == form_tag_copy) && (body >= 64'd4) && ($urandom_range(0, 1) == 1);
      for (longint unsigned i = 0; i < body; i++)
         stream_buf.push_back((nest && i < 64'd4) ? id[31 - 8*i -: 8] : 8'($urandom));
   endtask

   // Queues the stream that has been built, with the end-of-stream mark on its
   // final byte. With cut set, the stream ends at a random byte instead.
   task automatic end_stream(input bit cut);
      int unsigned keep;
      keep = stream_buf.size();
      if (cut)
         keep = $urandom_range(1, keep);
      for (int unsigned i = 0; i < keep; i++)
         push_item(stream_buf[i], i == keep - 1);
      stream_buf.delete();
   endtask

   // Half of the ids are the current form tag, so forms are common.
   function automatic logic [31:0] pick_id();
      return ($urandom_range(0, 1) == 1) ? form_tag_copy : 32'($urandom);
   endfunction

   // Mostly small sizes, so that forms shorter than their type come up often.
   function automatic logic [31:0] pick_size();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned start;
      int unsigned pick;
      start = bytes_queued;
      while (bytes_queued - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // A well-formed stream of a few chunks that ends on a chunk end.
            repeat ($urandom_range(1, 4))
               add_chunk(pick_id(), pick_size(), $urandom, 1 << 20);
            end_stream(1'b0);
         end else if (pick < 85) begin
            // A stream that stops at a random point, often inside a chunk
            // whose size has random high bits.
            if ($urandom_range(0, 1) == 1)
               add_chunk(pick_id(), pick_size(), $urandom, 1 << 20);
            add_chunk(pick_id(), $urandom, $urandom, $urandom_range(0, 12));
            end_stream(1'b1);
         end else begin
            // Noise: random bytes with an end mark now and then.
            repeat ($urandom_range(1, 24))
               push_item(8'($urandom), $urandom_range(0, 11) == 0);
         end
      end
   endtask

   // Waits until all bytes have been accepted and all results have been
   // checked. A short pause follows so the block is idle before a register
   // write.
   task automatic settle();
      while (byte_queue.size() != 0 || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The model copy of the tag changes on the edge where the write is taken.
   task automatic write_form_tag(input logic [31:0] value);
      @(posedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= value;
      do
         @(posedge clock);
      while (!(csr_if.valid && csr_if.ready));
      form_tag_copy = value;
      tag_settings++;
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      form_tag_copy  = FORM_TAG_RESET;
      clear_parse();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed cases, using the form tag that reset sets.
      // A chunk of size zero ends on its last size byte. It is followed by a
      // form whose size is below four, and that form ends the stream.
      add_chunk(32'h4441_5441, 32'd0, 32'd0, 0);
      add_chunk(FORM_TAG_RESET, 32'd1, 32'h494C_424D, 0);
      end_stream(1'b0);
      // The largest odd size rounds up and is held at all ones. The stream
      // stops two payload bytes in.
      add_chunk(FORM_TAG_RESET, 32'hFFFF_FFFF, 32'h494C_424D, 2);
      end_stream(1'b0);
      // A stream that stops inside a chunk id, with both extreme byte values.
      push_item(8'hFF, 1'b0);
      push_item(8'h00, 1'b1);
      // A chunk of odd size with its pad byte, then a form whose type fills
      // its whole size, so the form is empty.
      add_chunk(32'h424F_4459, 32'd1, 32'd0, 4);
      add_chunk(FORM_TAG_RESET, 32'd3, 32'h494C_424D, 4);
      end_stream(1'b0);

      run_random(260);
      settle();
      write_form_tag(32'h0000_0000);
      run_random(250);
      settle();
      write_form_tag(32'hFFFF_FFFF);
      run_random(250);
      settle();
      write_form_tag(32'($urandom));
      run_random(350);
      settle();
      write_form_tag(FORM_TAG_RESET);
      run_random(350);
      settle();
      repeat (8) @(posedge clock);

      $display("tb_top: %0d bytes checked under %0d form tag settings", results_seen,
               tag_settings);
      $display("tb_top: %0d chunk ends, %0d short forms, %0d truncated streams",
               chunk_ends, short_forms, truncations);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog. The slowest correct run is far below this.
   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
